// ----- hdl/bmhp_pkg.sv -----
package bmhp_pkg;
    localparam logic [2:0] OP_WRITE    = 3'd0;
    localparam logic [2:0] OP_HEAPIFY  = 3'd1;
    localparam logic [2:0] OP_PUSH     = 3'd2;
    localparam logic [2:0] OP_FITTEST  = 3'd3;
    localparam logic [2:0] OP_CONTAINS = 3'd4;
    localparam int COUNT_W = 7;
    localparam int INDEX_W = 6;
    localparam int FIELD_SCORE_W = 32;
    localparam int FIELD_PAYLOAD_W = 64;
endpackage

// ----- hdl/bounded_min_heap_population.sv -----
// Bounded binary min-heap of scored members, each with one payload word.
//
// Channels: input items (operation, entry_index, score, payload) and result
// items (result_score, result_payload, result_index, found) each move by a
// valid/ready transfer. One result per input item. The user must write
// member_count via i_cfg_we/i_cfg_data while the block is idle (not enforced).
//
// Scores and payloads live in two single-port memories (one access per
// cycle, read data registered). A small sequencer drives one shared compare
// unit over them. Push and heapify work by sift-down swaps; fittest and
// contains scan every live entry. The block is ready again the cycle the
// result appears, so one item finishes before the next begins.
//
// Reset: a clearing pass zeroes both memories; no item is taken meanwhile.
// member_count resets to 64.
// A finished result sits in the output register until taken. A stalled
// receiver holds the next item just before its root read, so at most one
// result waits while one item is in work.
module bounded_min_heap_population
    import bmhp_pkg::*;
#(
    parameter int CAPACITY     = 64,
    parameter int PAYLOAD_BITS = 64,
    parameter int SCORE_BITS   = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [COUNT_W-1:0]         i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [2:0]                 i_operation,
    input  logic [INDEX_W-1:0]         i_entry_index,
    input  logic [FIELD_SCORE_W-1:0]   i_score,
    input  logic [FIELD_PAYLOAD_W-1:0] i_payload,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [FIELD_SCORE_W-1:0]   o_result_score,
    output logic [FIELD_PAYLOAD_W-1:0] o_result_payload,
    output logic [INDEX_W-1:0]         o_result_index,
    output logic                       o_found
);
    localparam int AW = $clog2(CAPACITY);
    localparam int NW = AW + 1;

    // states
    localparam logic [3:0] S_CLR    = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_RD     = 4'd2;  // issue read of r_node
    localparam logic [3:0] S_RDL    = 4'd3;  // capture node, read left
    localparam logic [3:0] S_RDR    = 4'd4;  // capture left, read right
    localparam logic [3:0] S_CMP    = 4'd5;  // capture right, decide
    localparam logic [3:0] S_WN     = 4'd6;  // write child into node
    localparam logic [3:0] S_WC     = 4'd7;  // write node into child
    localparam logic [3:0] S_SCAN   = 4'd8;  // scan reads
    localparam logic [3:0] S_ROOT   = 4'd9;  // read root
    localparam logic [3:0] S_ROOTC  = 4'd10; // capture root
    localparam logic [3:0] S_OUT    = 4'd11;
    localparam logic [3:0] S_WR     = 4'd12;
    localparam logic [3:0] S_SCANL  = 4'd13; // last scan capture
    localparam logic [3:0] S_NEXT_F = 4'd14;

    typedef logic signed [SCORE_BITS-1:0] t_score;
    typedef logic [PAYLOAD_BITS-1:0]      t_pay;

    t_score mem_s [CAPACITY];
    t_pay   mem_p [CAPACITY];

    logic [3:0]         r_state, n_state;
    logic [COUNT_W-1:0] r_count;
    logic [NW-1:0]      r_n;        // live count
    logic [2:0]         r_op;
    logic [INDEX_W-1:0] r_idx;
    t_score             r_key;
    t_pay               r_pay;
    logic [NW-1:0]      r_node;     // sift node / scan pointer
    logic [NW-1:0]      r_hnode;    // heapify outer pointer
    t_score             r_ns, r_ls, r_rs;
    t_pay               r_np, r_lp, r_rp;
    logic               r_has_r;
    logic [NW-1:0]      r_pick;
    t_score             r_best_s;
    t_pay               r_best_p;
    logic [NW-1:0]      r_best_i;
    logic [NW-1:0]      r_sidx;     // index of data being captured in scan
    logic               r_found;
    logic [CAPACITY-1:0] r_reach;
    logic               r_ovalid;
    logic [FIELD_SCORE_W-1:0]   r_os;
    logic [FIELD_PAYLOAD_W-1:0] r_op_pay;
    logic [INDEX_W-1:0] r_oi;
    logic               r_of;

    // memory port
    logic          m_we;
    logic [AW-1:0] m_addr;
    t_score        m_ws;
    t_pay          m_wp;
    t_score        r_rds;
    t_pay          r_rdp;

    always_ff @(posedge i_clk) begin
        if (m_we) begin
            mem_s[m_addr] <= m_ws;
            mem_p[m_addr] <= m_wp;
        end
        r_rds <= mem_s[m_addr];
        r_rdp <= mem_p[m_addr];
    end

    // sift addressing
    logic [NW:0] left_w, right_w;
    assign left_w  = {r_node, 1'b0} + (NW+1)'(1);
    assign right_w = left_w + (NW+1)'(1);

    // shared compare unit
    t_score cmp_a, cmp_b;
    logic   cmp_lt;
    assign cmp_lt = cmp_a < cmp_b;

    t_score pick_s;
    always_comb begin
        cmp_a = r_rds;
        cmp_b = r_ls;
        unique case (r_state)
            S_CMP:   begin cmp_a = r_rds; cmp_b = r_ls; end
            S_WN:    begin cmp_a = pick_s; cmp_b = r_ns; end
            S_SCAN, S_SCANL: begin
                if (r_op == OP_FITTEST) begin
                    cmp_a = r_best_s; cmp_b = r_rds;
                end else begin
                    cmp_a = r_key; cmp_b = r_rds;
                end
            end
            default: begin cmp_a = r_rds; cmp_b = r_ls; end
        endcase
    end
    assign pick_s = (r_pick == left_w[NW-1:0]) ? r_ls : r_rs;

    logic [NW-1:0] par;
    assign par = (r_sidx - NW'(1)) >> 1;
    logic up_ok;
    assign up_ok = (r_sidx == '0) ? 1'b1 : r_reach[par[AW-1:0]];

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;
    assign o_result_score   = r_os;
    assign o_result_payload = r_op_pay;
    assign o_result_index   = r_oi;
    assign o_found          = r_of;

    logic [NW-1:0] cnt_live;
    assign cnt_live = (32'(r_count) > 32'(CAPACITY)) ? NW'(CAPACITY) : NW'(r_count);

    // heapify starts at the last live node
    logic [NW-1:0] heap_last;
    assign heap_last = cnt_live - NW'(1);

    t_score in_key;
    assign in_key = t_score'(i_score[SCORE_BITS-1:0]);

    always_comb begin
        m_we = 1'b0;
        m_addr = r_node[AW-1:0];
        m_ws = r_ns;
        m_wp = r_np;
        unique case (r_state)
            S_CLR:  begin m_we = 1'b1; m_ws = '0; m_wp = '0; end
            // push overwrites the root here before its sift
            S_WR:   begin m_we = (r_op == OP_PUSH) || (32'(r_idx) < 32'(CAPACITY));
                          m_addr = (r_op == OP_PUSH) ? '0 : AW'(r_idx);
                          m_ws = r_key; m_wp = r_pay; end
            S_RD:   m_addr = r_node[AW-1:0];
            S_RDL:  m_addr = left_w[AW-1:0];
            S_RDR:  m_addr = right_w[AW-1:0];
            S_WN:   begin m_we = cmp_lt; m_addr = r_node[AW-1:0];
                          m_ws = pick_s;
                          m_wp = (r_pick == left_w[NW-1:0]) ? r_lp : r_rp; end
            S_WC:   begin m_we = 1'b1; m_addr = r_pick[AW-1:0];
                          m_ws = r_ns; m_wp = r_np; end
            S_SCAN: m_addr = r_node[AW-1:0];
            S_ROOT: m_addr = '0;
            default: m_addr = r_node[AW-1:0];
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:   n_state = (r_node == NW'(CAPACITY-1)) ? S_IDLE : S_CLR;
            S_IDLE:  n_state = S_IDLE;
            default: n_state = r_state;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_count  <= COUNT_W'(64);
            r_node   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) r_count <= i_cfg_data;
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_CLR: begin
                    r_node  <= r_node + NW'(1);
                    r_state <= n_state;
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_op    <= i_operation;
                        r_idx   <= i_entry_index;
                        r_key   <= in_key;
                        r_pay   <= i_payload[PAYLOAD_BITS-1:0];
                        r_n     <= cnt_live;
                        r_found <= 1'b0;
                        r_reach <= '0;
                        r_best_i <= '0;
                        r_node  <= (i_operation == OP_HEAPIFY) ? heap_last : '0;
                        r_hnode <= (i_operation == OP_HEAPIFY) ? heap_last : '0;
                        priority case (i_operation)
                            OP_WRITE: r_state <= S_WR;
                            OP_PUSH:  r_state <= S_WR;
                            OP_HEAPIFY: begin
                                if (cnt_live == '0) r_state <= S_ROOT;
                                else r_state <= S_RD;
                            end
                            OP_FITTEST, OP_CONTAINS: begin
                                r_sidx  <= '0;
                                r_state <= (cnt_live == '0) ? S_ROOT : S_SCAN;
                            end
                            default: r_state <= S_ROOT;
                        endcase
                    end
                end
                S_WR: r_state <= (r_op == OP_PUSH) ? S_RD : S_ROOT;
                S_RD: begin
                    if (left_w >= (NW+1)'(r_n)) r_state <= S_NEXT_F;
                    else r_state <= S_RDL;
                end
                S_RDL: begin
                    r_ns <= r_rds; r_np <= r_rdp;
                    r_has_r <= right_w < (NW+1)'(r_n);
                    r_state <= S_RDR;
                end
                S_RDR: begin
                    r_ls <= r_rds; r_lp <= r_rdp;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_rs <= r_rds; r_rp <= r_rdp;
                    // right strictly smaller than left picks right
                    if (r_has_r && cmp_lt) r_pick <= right_w[NW-1:0];
                    else r_pick <= left_w[NW-1:0];
                    r_state <= S_WN;
                end
                S_WN: begin
                    if (cmp_lt) r_state <= S_WC;
                    else r_state <= S_NEXT_F;
                end
                S_WC: begin
                    r_node  <= r_pick;
                    r_state <= S_RD;
                end
                S_SCAN: begin
                    // issue read of r_node, capture previous (r_sidx = r_node-1)
                    if (r_node != '0) begin
                        if (r_op == OP_FITTEST) begin
                            if (r_sidx == '0 || cmp_lt) begin
                                r_best_s <= r_rds; r_best_p <= r_rdp; r_best_i <= r_sidx;
                            end
                        end else begin
                            if (up_ok && !cmp_lt) begin
                                r_reach[r_sidx[AW-1:0]] <= 1'b1;
                                if (r_rdp == r_pay) r_found <= 1'b1;
                            end
                        end
                        r_sidx <= r_sidx + NW'(1);
                    end
                    r_node <= r_node + NW'(1);
                    if (r_node + NW'(1) == r_n) r_state <= S_SCANL;
                end
                S_SCANL: begin
                    if (r_op == OP_FITTEST) begin
                        if (r_sidx == '0 || cmp_lt) begin
                            r_best_s <= r_rds; r_best_p <= r_rdp; r_best_i <= r_sidx;
                        end
                    end else if (up_ok && !cmp_lt && r_rdp == r_pay) begin
                        r_found <= 1'b1;
                    end
                    r_state <= S_ROOT;
                end
                S_NEXT_F: begin
                    // sift finished; heapify moves to the next lower node
                    if (r_op == OP_HEAPIFY && r_hnode != '0) begin
                        r_hnode <= r_hnode - NW'(1);
                        r_node  <= r_hnode - NW'(1);
                        r_state <= S_RD;
                    end else begin
                        r_state <= S_ROOT;
                    end
                end
                // wait here while the previous result is still unclaimed
                S_ROOT:  if (!r_ovalid || i_ready) r_state <= S_ROOTC;
                S_ROOTC: begin
                    if (r_op == OP_FITTEST && r_n != '0) begin
                        r_os     <= FIELD_SCORE_W'(r_best_s);
                        r_op_pay <= FIELD_PAYLOAD_W'(r_best_p);
                        r_oi     <= INDEX_W'(r_best_i);
                    end else begin
                        r_os     <= FIELD_SCORE_W'(r_rds);
                        r_op_pay <= FIELD_PAYLOAD_W'(r_rdp);
                        r_oi     <= '0;
                    end
                    r_of     <= (r_op == OP_CONTAINS) && r_found;
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
